// ===== sv/ppvm_pkg.sv =====
package ppvm_pkg;

  localparam int unsigned RateW  = 17;
  localparam int unsigned DivNW  = 41;
  localparam int unsigned DivDW  = 17;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_PLAY     = 3'd1,
    OP_STOP     = 3'd2,
    OP_STOP_ALL = 3'd3,
    OP_MIX      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    REG_OUTPUT_RATE = 1'b0,
    REG_STEREO_MODE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAY_MUL,
    S_PLAY_DIV,
    S_PLAY_WR,
    S_STOP_RD,
    S_STOP_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_MIX_RD,
    S_MIX_SRD,
    S_MIX_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] length;
    logic [32:0] offset;
    logic [31:0] step;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
    logic [15:0] handle;
  } voice_t;

endpackage

// ===== sv/ppvm_div.sv =====
module ppvm_div
  import ppvm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [DivDW:0]   rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivDW+1:0] trial;

  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivNW-1]} - {2'b00, den_q};
    if (start_i) begin
      quo_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDW+1]) begin
        rem_d = trial[DivDW:0];
        quo_d = {quo_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivDW-1:0], quo_q[DivNW-1]};
        quo_d = {quo_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/ppvm_vtab.sv =====
module ppvm_vtab
  import ppvm_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  voice_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output voice_t          rdata_o
);

  voice_t mem [Depth];
  voice_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pitched_panned_voice_mixer_unit.sv =====
// Sample write, stop-all and unused ops go straight to the result; play derives the voice
// step in the 41-step shift-subtract divider; stop by handle searches, compacts on a hit.
// Mix tick takes each playing voice in turn: one voice table read, one sample store
// read and one multiply-accumulate per channel and voice, stepped by the sequencer.
// One transaction in flight; input is stalled until its result is registered.
// Reset clears voice count, handle counter, sequencer and output valid; registers return
// to 44100 Hz and stereo. Sample store and voice table are not cleared.
module pitched_panned_voice_mixer_unit
  import ppvm_pkg::*;
#(
  parameter int unsigned VOICES       = 16,
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [RateW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [15:0]        mem_addr_i,
  input  logic signed [15:0] mem_data_i,
  input  logic [15:0]        sample_base_i,
  input  logic [16:0]        sample_length_i,
  input  logic [16:0]        sample_rate_i,
  input  logic [15:0]        freq_ratio_i,
  input  logic [15:0]        amplitude_i,
  input  logic signed [15:0] pan_i,
  input  logic [15:0]        stop_handle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [15:0]        handle_o,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [4:0]         active_voices_o
);

  localparam int unsigned AW   = $clog2(SAMPLE_WORDS);
  localparam int unsigned CW   = $clog2(VOICES + 1);
  localparam int unsigned IW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned AccW = 34 + $clog2(VOICES + 1);

  state_e state_q, state_d;

  logic [RateW-1:0] rate_q;
  logic             stereo_q;

  logic [2:0]  op_q;
  logic [15:0] base_q, ratio_q, amp_q, hsel_q;
  logic [16:0] len_q, srate_q;
  logic signed [15:0] pan_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] r_q, r_d, w_q, w_d;
  logic [15:0]   next_handle_q, next_handle_d;

  logic [32:0] prod;
  logic [15:0] gl_q, gr_q;
  logic [16:0] pan_l, pan_r;
  logic [32:0] mul_l, mul_r;

  logic signed [AccW-1:0] accl_q, accl_d, accr_q, accr_d;
  logic [1:0]  res_status_q, res_status_d;
  logic [15:0] res_handle_q, res_handle_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [15:0]        out_handle_q;
  logic signed [15:0] out_left_q, out_right_q;
  logic [4:0]         out_active_q;

  logic signed [15:0] store [SAMPLE_WORDS];
  logic signed [15:0] sample_q;
  logic [17:0]        rd_sum;

  voice_t vt_rdata, vt_wdata, vcur_q;
  logic   vt_we;
  logic [IW-1:0] vt_waddr;

  logic             div_start;
  logic             div_done;
  logic [DivNW-1:0] div_quo;
  logic [DivDW-1:0] div_den;
  logic [31:0]      step_sat;

  logic [33:0] nx;
  logic        keep;
  logic signed [32:0] pl, pr;
  logic        accept, out_free;
  logic signed [15:0] mix_l, mix_r;

  function automatic logic signed [15:0] sat_out(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    q = (acc + (acc[AccW-1] ? AccW'(16383) : AccW'(0))) >>> 14;
    if (q > AccW'(32767)) begin
      return 16'sh7FFF;
    end else if (q < -AccW'(32768)) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign pan_l = 17'd32768 - {pan_q[15], pan_q};
  assign pan_r = 17'd32768 + {pan_q[15], pan_q};
  assign mul_l = amp_q * pan_l;
  assign mul_r = amp_q * pan_r;
  assign prod  = 33'(ratio_q) * 33'(srate_q);

  assign div_den  = (rate_q == '0) ? DivDW'(1) : rate_q;
  assign step_sat = (|div_quo[DivNW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];

  assign nx     = {1'b0, vcur_q.offset} + {2'b00, vcur_q.step};
  assign keep   = nx < {1'b0, vcur_q.length, 16'h0000};
  assign pl     = sample_q * $signed({1'b0, vcur_q.gain_l});
  assign pr     = sample_q * $signed({1'b0, vcur_q.gain_r});
  assign rd_sum = {2'b00, vt_rdata.base} + {1'b0, vt_rdata.offset[32:16]};

  assign mix_l = sat_out(accl_q);
  assign mix_r = stereo_q ? sat_out(accr_q) : 16'sd0;

  ppvm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({8'h00, prod} << 8),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ppvm_vtab #(
    .Depth (VOICES),
    .IdxW  (IW)
  ) u_vtab (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata),
    .raddr_i (r_q[IW-1:0]),
    .rdata_o (vt_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    r_d           = r_q;
    w_d           = w_q;
    next_handle_d = next_handle_q;
    accl_d        = accl_q;
    accr_d        = accr_q;
    res_status_d  = res_status_q;
    res_handle_d  = res_handle_q;
    div_start     = 1'b0;
    vt_we         = 1'b0;
    vt_waddr      = w_q[IW-1:0];
    vt_wdata      = vt_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          accl_d       = '0;
          accr_d       = '0;
          res_status_d = ST_OK;
          res_handle_d = '0;
          r_d          = '0;
          w_d          = '0;
          state_d      = S_DONE;
          case (op_i)
            OP_PLAY: begin
              if (count_q >= CW'(VOICES)) begin
                res_status_d = ST_FULL;
              end else begin
                state_d = S_PLAY_MUL;
              end
            end
            OP_STOP: begin
              if (count_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                state_d = S_STOP_RD;
              end
            end
            OP_STOP_ALL: count_d = '0;
            OP_MIX:      state_d = S_MIX_RD;
            default:     ;
          endcase
        end
      end
      S_PLAY_MUL: begin
        div_start = 1'b1;
        state_d   = S_PLAY_DIV;
      end
      S_PLAY_DIV: begin
        if (div_done) begin
          state_d = S_PLAY_WR;
        end
      end
      S_PLAY_WR: begin
        vt_we           = 1'b1;
        vt_waddr        = count_q[IW-1:0];
        vt_wdata.base   = base_q;
        vt_wdata.length = len_q;
        vt_wdata.offset = '0;
        vt_wdata.step   = step_sat;
        vt_wdata.gain_l = gl_q;
        vt_wdata.gain_r = gr_q;
        vt_wdata.handle = next_handle_q;
        res_handle_d    = next_handle_q;
        next_handle_d   = next_handle_q + 16'd1;
        count_d         = count_q + 1'b1;
        state_d         = S_DONE;
      end
      S_STOP_RD: begin
        if (r_q >= count_q) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          state_d = S_STOP_CMP;
        end
      end
      S_STOP_CMP: begin
        r_d = r_q + 1'b1;
        if (vt_rdata.handle == hsel_q) begin
          w_d     = r_q;
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_STOP_RD;
        end
      end
      S_SHIFT_RD: begin
        if (r_q >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        vt_we   = 1'b1;
        r_d     = r_q + 1'b1;
        w_d     = w_q + 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_MIX_RD: begin
        if (r_q >= count_q) begin
          count_d = w_q;
          state_d = S_DONE;
        end else begin
          state_d = S_MIX_SRD;
        end
      end
      S_MIX_SRD: state_d = S_MIX_ACC;
      S_MIX_ACC: begin
        accl_d          = accl_q + AccW'(pl);
        accr_d          = accr_q + AccW'(pr);
        vt_wdata        = vcur_q;
        vt_wdata.offset = nx[32:0];
        if (keep) begin
          vt_we = 1'b1;
          w_d   = w_q + 1'b1;
        end
        r_d     = r_q + 1'b1;
        state_d = S_MIX_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      next_handle_q <= '0;
      rate_q        <= RateW'(44100);
      stereo_q      <= 1'b1;
      out_valid_q   <= 1'b0;
      r_q           <= '0;
      w_q           <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      next_handle_q <= next_handle_d;
      r_q           <= r_d;
      w_q           <= w_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_OUTPUT_RATE: rate_q   <= cfg_data_i;
          REG_STEREO_MODE: stereo_q <= cfg_data_i[0];
          default:         ;
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    accl_q       <= accl_d;
    accr_q       <= accr_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    if (accept) begin
      op_q    <= op_i;
      base_q  <= sample_base_i;
      len_q   <= sample_length_i;
      srate_q <= sample_rate_i;
      ratio_q <= freq_ratio_i;
      amp_q   <= amplitude_i;
      pan_q   <= pan_i;
      hsel_q  <= stop_handle_i;
    end
    if (state_q == S_PLAY_MUL) begin
      gl_q <= mul_l[31:16];
      gr_q <= mul_r[31:16];
    end
    if (state_q == S_MIX_SRD) begin
      vcur_q <= vt_rdata;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_left_q   <= (op_q == OP_MIX) ? mix_l : 16'sd0;
      out_right_q  <= (op_q == OP_MIX) ? mix_r : 16'sd0;
      out_active_q <= 5'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_i == OP_WRITE) begin
      store[AW'(mem_addr_i)] <= mem_data_i;
    end
    sample_q <= store[AW'(rd_sum)];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign handle_o        = out_handle_q;
  assign left_out_o      = out_left_q;
  assign right_out_o     = out_right_q;
  assign active_voices_o = out_active_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(VOICES))
    else $error("voice count above table depth");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_PLAY_DIV)
    else $error("divider finished outside play");

  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MIX_ACC |-> w_q <= r_q)
    else $error("compaction write pointer passed read pointer");

  a_play_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PLAY_WR |-> count_q < CW'(VOICES))
    else $error("play write into full table");

endmodule

// ===== dv/tb_pitched_panned_voice_mixer_unit.sv =====
module tb_pitched_panned_voice_mixer_unit;
  import ppvm_pkg::*;

  localparam int unsigned NumVoices  = 16;
  localparam int unsigned StoreWords = 65536;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned HoldOff    = 400;
  localparam int unsigned RandPerPh  = 255;
  localparam logic [2:0]  OP_SPARE_LO = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [15:0]        addr;
    logic signed [15:0] data;
    logic [15:0]        base;
    logic [16:0]        len;
    logic [16:0]        srate;
    logic [15:0]        ratio;
    logic [15:0]        amp;
    logic signed [15:0] pan;
    logic [15:0]        hnd;
  } mix_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [15:0]        handle;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [4:0]         active;
  } mix_res_t;

  typedef struct {
    mix_cmd_t cmd;
    bit       typed;
    mix_res_t res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [RateW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         op_i;
  logic [15:0]        mem_addr_i;
  logic signed [15:0] mem_data_i;
  logic [15:0]        sample_base_i;
  logic [16:0]        sample_length_i;
  logic [16:0]        sample_rate_i;
  logic [15:0]        freq_ratio_i;
  logic [15:0]        amplitude_i;
  logic signed [15:0] pan_i;
  logic [15:0]        stop_handle_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [15:0]        handle_o;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic [4:0]         active_voices_o;

  pitched_panned_voice_mixer_unit dut (.*);

  logic signed [15:0] store_word [StoreWords];
  bit                 store_written [StoreWords];
  logic [15:0]        v_base [NumVoices];
  logic [16:0]        v_len [NumVoices];
  longint unsigned    v_off [NumVoices];
  logic [31:0]        v_step [NumVoices];
  longint             v_gl [NumVoices];
  longint             v_gr [NumVoices];
  logic [15:0]        v_hnd [NumVoices];
  int unsigned        v_count;
  logic [15:0]        next_hnd;
  logic [16:0]        out_rate;
  bit                 stereo;

  mix_res_t           pending_frames [$];
  dir_row_t           dir_rows [$];
  bit                 failed;
  bit                 quiet;
  bit                 hold_req;
  int unsigned        idle_cycles;
  int unsigned        sent_items;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void drop_voice(int unsigned k);
    for (int unsigned l = k + 1; l < v_count; l++) begin
      v_base[l-1] = v_base[l];
      v_len[l-1]  = v_len[l];
      v_off[l-1]  = v_off[l];
      v_step[l-1] = v_step[l];
      v_gl[l-1]   = v_gl[l];
      v_gr[l-1]   = v_gr[l];
      v_hnd[l-1]  = v_hnd[l];
    end
    if (v_count > 0) v_count--;
  endfunction

  function automatic logic [15:0] sat_frame(longint acc);
    longint q;
    q = (acc >= 0) ? (acc >>> 14) : -((-acc) >>> 14);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic mix_res_t mix_apply(mix_cmd_t c);
    mix_res_t        r;
    longint unsigned step, div, nx;
    longint          accl, accr, w;
    int unsigned     k;
    logic [15:0]     a;
    r = '{ST_OK, 16'd0, 16'sd0, 16'sd0, 5'd0};
    case (c.op)
      OP_WRITE: begin
        store_word[c.addr]    = c.data;
        store_written[c.addr] = 1'b1;
      end
      OP_PLAY: begin
        if (v_count >= NumVoices) begin
          r.status = ST_FULL;
        end else begin
          div  = (out_rate == 0) ? 1 : out_rate;
          step = ((longint'(c.ratio) * longint'(c.srate)) << 8) / div;
          if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
          v_base[v_count] = c.base;
          v_len[v_count]  = c.len;
          v_off[v_count]  = 0;
          v_step[v_count] = step[31:0];
          v_gl[v_count]   = (longint'(c.amp) * (32768 - longint'(c.pan))) >>> 16;
          v_gr[v_count]   = (longint'(c.amp) * (32768 + longint'(c.pan))) >>> 16;
          v_hnd[v_count]  = next_hnd;
          v_count++;
          r.handle = next_hnd;
          next_hnd = next_hnd + 16'd1;
        end
      end
      OP_STOP: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < v_count; k++) begin
          if (v_hnd[k] == c.hnd) begin
            drop_voice(k);
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_STOP_ALL: v_count = 0;
      OP_MIX: begin
        accl = 0;
        accr = 0;
        k = 0;
        while (k < v_count) begin
          a = v_base[k] + v_off[k][31:16];
          w = longint'(store_word[a]);
          nx = v_off[k] + v_step[k];
          accl += w * v_gl[k];
          accr += w * v_gr[k];
          if (nx >= (longint'(v_len[k]) << 16)) begin
            drop_voice(k);
          end else begin
            v_off[k] = nx;
            k++;
          end
        end
        r.left  = sat_frame(accl);
        r.right = stereo ? sat_frame(accr) : 16'sd0;
      end
      default: ;
    endcase
    r.active = v_count[4:0];
    return r;
  endfunction

  task automatic send_cmd(mix_cmd_t c, bit typed, mix_res_t res);
    int unsigned gap;
    mix_res_t    pred;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= c.op;
    mem_addr_i      <= c.addr;
    mem_data_i      <= c.data;
    sample_base_i   <= c.base;
    sample_length_i <= c.len;
    sample_rate_i   <= c.srate;
    freq_ratio_i    <= c.ratio;
    amplitude_i     <= c.amp;
    pan_i           <= c.pan;
    stop_handle_i   <= c.hnd;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    pred = mix_apply(c);
    pending_frames.push_back(typed ? res : pred);
  endtask

  function automatic mix_cmd_t rand_cmd(logic [2:0] op);
    mix_cmd_t c;
    c.op    = op;
    c.addr  = 16'($urandom);
    c.data  = 16'($urandom);
    c.base  = 16'($urandom);
    c.len   = 17'($urandom);
    c.srate = 17'($urandom);
    c.ratio = 16'($urandom);
    c.amp   = 16'($urandom);
    c.pan   = 16'($urandom);
    c.hnd   = 16'($urandom);
    return c;
  endfunction

  task automatic send_pred(mix_cmd_t c);
    send_cmd(c, 1'b0, '{ST_OK, 16'd0, 16'sd0, 16'sd0, 5'd0});
  endtask

  // fill every unwritten store word a playing voice is about to read, then mix
  task automatic send_mix();
    mix_cmd_t    w;
    logic [15:0] a;
    for (int unsigned k = 0; k < v_count; k++) begin
      a = v_base[k] + v_off[k][31:16];
      if (!store_written[a]) begin
        w = rand_cmd(OP_WRITE);
        w.addr = a;
        send_pred(w);
      end
    end
    send_pred(rand_cmd(OP_MIX));
  endtask

  task automatic send_row(dir_row_t row);
    if (row.cmd.op == OP_MIX && !row.typed) send_mix();
    else send_cmd(row.cmd, row.typed, row.res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [RateW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OUTPUT_RATE) out_rate = val;
    else stereo = val[0];
  endtask

  function automatic void add_row(logic [2:0] op, logic [15:0] addr, logic signed [15:0] data,
                                  logic [15:0] base, logic [16:0] len, logic [15:0] ratio,
                                  logic [15:0] amp, logic signed [15:0] pan, logic [15:0] hnd,
                                  bit typed, mix_res_t res);
    dir_row_t row;
    row.cmd   = '{op, addr, data, base, len, 17'd44100, ratio, amp, pan, hnd};
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  task automatic send_random_cmd();
    mix_cmd_t    c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_pred(rand_cmd(OP_WRITE));
    end else if (pick < 42) begin
      c = rand_cmd(OP_PLAY);
      pick = $urandom_range(0, 9);
      if (pick < 7) c.len = 17'($urandom_range(1, 48));
      else if (pick == 7) c.len = 17'd0;
      else if (pick == 8) c.len = 17'h10000;
      pick = $urandom_range(0, 9);
      if (pick < 7) c.ratio = 16'($urandom_range(128, 1024));
      else if (pick == 7) c.ratio = 16'd0;
      if ($urandom_range(0, 4) != 0) c.srate = 17'($urandom_range(8000, 48000));
      send_pred(c);
    end else if (pick < 52) begin
      c = rand_cmd(OP_STOP);
      if (v_count > 0 && $urandom_range(0, 3) != 0) c.hnd = v_hnd[$urandom_range(0, v_count - 1)];
      send_pred(c);
    end else if (pick < 55) begin
      send_pred(rand_cmd(OP_STOP_ALL));
    end else if (pick < 97) begin
      send_mix();
    end else begin
      send_pred(rand_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
    end
  endtask

  initial begin
    mix_res_t    zero_res;
    int unsigned ph_start;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_OUTPUT_RATE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    op_i            = OP_WRITE;
    mem_addr_i      = '0;
    mem_data_i      = '0;
    sample_base_i   = '0;
    sample_length_i = '0;
    sample_rate_i   = '0;
    freq_ratio_i    = '0;
    amplitude_i     = '0;
    pan_i           = '0;
    stop_handle_i   = '0;
    failed          = 1'b0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    sent_items      = 0;
    v_count         = 0;
    next_hnd        = '0;
    out_rate        = 17'd44100;
    stereo          = 1'b1;
    zero_res        = '{ST_OK, 16'd0, 16'sd0, 16'sd0, 5'd0};

    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1,
            '{ST_NOT_FOUND, 16'd0, 16'sd0, 16'sd0, 5'd0});
    add_row(OP_STOP_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_SPARE_LO, 16'hFFFF, -1, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, -1, 16'hFFFF,
            1, zero_res);
    add_row(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_WRITE, 16'd0, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_WRITE, 16'hFFFF, -16'sd32768, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_WRITE, 16'd1, -16'sd1, 0, 0, 0, 0, 0, 0, 1, zero_res);
    add_row(OP_PLAY, 0, 0, 16'd0, 17'd2, 16'd256, 16'hFFFF, -16'sd32768, 0, 1,
            '{ST_OK, 16'd0, 16'sd0, 16'sd0, 5'd1});
    add_row(OP_PLAY, 0, 0, 16'hFFFF, 17'd2, 16'd256, 16'hFFFF, 16'sh7FFF, 0, 1,
            '{ST_OK, 16'd1, 16'sd0, 16'sd0, 5'd2});
    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);
    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);
    add_row(OP_PLAY, 0, 0, 16'd0, 17'd0, 16'd256, 16'd16384, 16'sd0, 0, 0, zero_res);
    add_row(OP_PLAY, 0, 0, 16'd1, 17'h10000, 16'd0, 16'hFFFF, 16'sd0, 0, 0, zero_res);
    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);
    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);
    add_row(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 16'd3, 0, zero_res);
    add_row(OP_PLAY, 0, 0, 16'd0, 17'd1, 16'hFFFF, 16'd0, 16'sd0, 0, 0, zero_res);
    add_row(OP_PLAY, 0, 0, 16'hFFFF, 17'd2, 16'd512, 16'd20000, -16'sd100, 0, 0, zero_res);
    add_row(OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);
    add_row(OP_STOP_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, zero_res);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_OUTPUT_RATE, 17'd44100);
    write_reg(REG_STEREO_MODE, 1'b1);
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_OUTPUT_RATE, 17'd8000);   write_reg(REG_STEREO_MODE, 1'b0); end
        1: begin write_reg(REG_OUTPUT_RATE, 17'd96000);  write_reg(REG_STEREO_MODE, 1'b1); end
        2: begin write_reg(REG_OUTPUT_RATE, 17'd0);      write_reg(REG_STEREO_MODE, 1'b1); end
        3: begin write_reg(REG_OUTPUT_RATE, 17'h1FFFF);  write_reg(REG_STEREO_MODE, 1'b0); end
        4: begin write_reg(REG_OUTPUT_RATE, 17'd22050);  write_reg(REG_STEREO_MODE, 1'b1); end
        default: begin write_reg(REG_OUTPUT_RATE, 17'd44100); write_reg(REG_STEREO_MODE, 1'b1); end
      endcase
      quiet = (ph == 3);
      ph_start = sent_items;
      for (int n = 0; sent_items - ph_start < RandPerPh; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        send_random_cmd();
      end
      drain();
    end

    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned gap;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldOff;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    mix_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        $error("result with nothing pending");
        failed = 1'b1;
      end else begin
        e = pending_frames.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (handle_o !== e.handle) begin
          $error("handle exp %0d got %0d", e.handle, handle_o);
          failed = 1'b1;
        end
        if (left_out_o !== e.left) begin
          $error("left_out exp %0d got %0d", e.left, left_out_o);
          failed = 1'b1;
        end
        if (right_out_o !== e.right) begin
          $error("right_out exp %0d got %0d", e.right, right_out_o);
          failed = 1'b1;
        end
        if (active_voices_o !== e.active) begin
          $error("active_voices exp %0d got %0d", e.active, active_voices_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
